// File: hdl/i2c_master_message_sequencer_unit_assert.svh
// assertion macros for the message sequencer
`ifndef I2C_MASTER_MESSAGE_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_MESSAGE_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define IMSQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("imsq assertion failed");

`define IMSQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("imsq assertion failed");

`else

`define IMSQ_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define IMSQ_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hdl/imsq_pkg.sv
`default_nettype none

package imsq_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int MAX_MSGS    = 8;
  localparam int MW          = $clog2(MAX_MSGS);
  localparam int IN_DEPTH    = 4;
  localparam int IN_AW       = $clog2(IN_DEPTH);
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_AW      = $clog2(OUT_DEPTH);
  localparam int LVL_W       = $clog2(OUT_DEPTH + 1);
  localparam int IN_LVL_W    = $clog2(IN_DEPTH + 1);

  localparam logic [2:0] CMD_LOAD_BYTE = 3'd0;
  localparam logic [2:0] CMD_LOAD_DESC = 3'd1;
  localparam logic [2:0] CMD_START     = 3'd2;
  localparam logic [2:0] CMD_EVENT     = 3'd3;
  localparam logic [2:0] CMD_TIMEOUT   = 3'd4;
  localparam logic [2:0] CMD_READ      = 3'd5;

  localparam logic [3:0] EV_RX   = 4'b0001;
  localparam logic [3:0] EV_TX   = 4'b0010;
  localparam logic [3:0] EV_COMP = 4'b0100;
  localparam logic [3:0] EV_ERR  = 4'b1000;

  localparam logic [1:0] STAT_NONE    = 2'd0;
  localparam logic [1:0] STAT_OK      = 2'd1;
  localparam logic [1:0] STAT_IO_ERR  = 2'd2;
  localparam logic [1:0] STAT_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [9:0]  buf_index;
    logic [7:0]  byte_value;
    logic [2:0]  msg_index;
    logic [6:0]  dev_addr;
    logic        is_read;
    logic [10:0] msg_length;
    logic [3:0]  msg_count;
    logic        ev_error;
    logic        ev_rx_ready;
    logic        ev_tx_ready;
    logic        ev_tx_complete;
  } in_item_t;

  typedef struct packed {
    logic       mode_load;
    logic [6:0] target_addr;
    logic       read_mode;
    logic       send_start;
    logic       send_stop;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [3:0] watch_mask;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } res_item_t;

  typedef struct packed {
    logic [6:0]  addr;
    logic        rd;
    logic [10:0] len;
  } desc_t;

  typedef struct packed {
    logic load_byte;
    logic load_desc;
    logic start;
    logic ev;
    logic timeout;
    logic read;
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  ev_flags;
    logic [9:0]  buf_index;
    logic [7:0]  byte_value;
    logic [2:0]  msg_index;
    desc_t       desc;
    logic [3:0]  msg_count;
  } work_t;

endpackage

`default_nettype wire

// File: hdl/imsq_front.sv
`default_nettype none

module imsq_front
  import imsq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t req,
  output logic          head_valid,
  output work_t         head,
  input  wire logic     head_pop
);

  work_t                q [IN_DEPTH];
  logic [IN_AW-1:0]     wr_ptr;
  logic [IN_AW-1:0]     rd_ptr;
  logic [IN_LVL_W-1:0]  count;
  work_t                w;
  logic                 push_ok;
  logic                 pop_ok;

  always_comb begin
    w = '0;
    w.ev_flags   = {req.ev_error, req.ev_tx_complete, req.ev_tx_ready, req.ev_rx_ready};
    w.buf_index  = req.buf_index;
    w.byte_value = req.byte_value;
    w.msg_index  = req.msg_index;
    w.desc.addr  = req.dev_addr;
    w.desc.rd    = req.is_read;
    w.desc.len   = req.msg_length;
    w.msg_count  = req.msg_count;
    unique case (req.cmd)
      CMD_LOAD_BYTE: w.kind.load_byte = 1'b1;
      CMD_LOAD_DESC: w.kind.load_desc = 1'b1;
      CMD_START:     w.kind.start     = 1'b1;
      CMD_EVENT:     w.kind.ev        = 1'b1;
      CMD_TIMEOUT:   w.kind.timeout   = 1'b1;
      CMD_READ:      w.kind.read      = 1'b1;
      default:       w.kind           = '0;
    endcase
  end

  assign full       = (count == IN_LVL_W'(IN_DEPTH));
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];
  assign push_ok    = push && !full;
  assign pop_ok     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= w;
    end
  end

endmodule

`default_nettype wire

// File: hdl/imsq_res_queue.sv
`default_nettype none

module imsq_res_queue
  import imsq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_push,
  input  wire res_item_t in_data,
  output logic [LVL_W-1:0] level,
  output logic           empty,
  input  wire logic      pop,
  output res_item_t      res
);

  res_item_t         q [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr;
  logic [OUT_AW-1:0] rd_ptr;
  logic              pop_ok;

  assign empty  = (level == '0);
  assign res    = q[rd_ptr];
  assign pop_ok = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (in_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({in_push, pop_ok})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_push) begin
      q[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: hdl/imsq_back.sv
`default_nettype none
`include "i2c_master_message_sequencer_unit_assert.svh"

module imsq_back
  import imsq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             head_valid,
  input  wire work_t            head,
  output logic                  head_pop,
  input  wire logic [LVL_W-1:0] res_level,
  output logic                  res_push,
  output res_item_t             res_data
);

  logic [7:0]    mem [STORE_DEPTH];
  desc_t         desc_tbl [MAX_MSGS];

  logic          busy, busy_next;
  logic [3:0]    event_mask, event_mask_next;
  logic [MW-1:0] cur_msg, cur_msg_next;
  logic [3:0]    msgs_left, msgs_left_next;
  logic [10:0]   byte_count, byte_count_next;
  logic [AW-1:0] msg_offset, msg_offset_next;
  desc_t         cur_desc, cur_desc_next;

  logic [7:0]    rdata;
  logic          b_valid;
  res_item_t     b_res;
  logic          b_tx_sel;
  logic          b_rd_sel;

  logic [LVL_W:0] fill;
  logic          a_fire;
  logic [3:0]    pending;
  res_item_t     res;
  logic          tx_sel;
  logic          rd_sel;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic          desc_we;
  logic          do_begin;
  logic [MW-1:0] desc_idx;
  desc_t         begin_desc;
  logic [AW-1:0] begin_off;
  logic [AW-1:0] off_adv;
  logic [10:0]   bc_inc;
  logic          do_finish;
  logic [1:0]    fin_code;

  assign fill     = {1'b0, res_level} + {{LVL_W{1'b0}}, b_valid};
  assign a_fire   = head_valid && (fill < (LVL_W + 1)'(OUT_DEPTH));
  assign head_pop = a_fire;
  assign pending  = head.ev_flags & event_mask;
  assign bc_inc   = byte_count + 11'd1;
  assign off_adv  = msg_offset + AW'(cur_desc.len);
  assign desc_idx = head.kind.start ? '0 : cur_msg + 1'b1;
  assign begin_desc = desc_tbl[desc_idx];

  always_comb begin
    busy_next       = busy;
    event_mask_next = event_mask;
    cur_msg_next    = cur_msg;
    msgs_left_next  = msgs_left;
    byte_count_next = byte_count;
    msg_offset_next = msg_offset;
    cur_desc_next   = cur_desc;
    res       = '0;
    tx_sel    = 1'b0;
    rd_sel    = 1'b0;
    mem_we    = 1'b0;
    waddr     = AW'(head.buf_index);
    wdata     = head.byte_value;
    raddr     = AW'(head.buf_index);
    desc_we   = 1'b0;
    do_begin  = 1'b0;
    begin_off = '0;
    do_finish = 1'b0;
    fin_code  = STAT_NONE;

    if (head.kind.load_byte) begin
      mem_we = 1'b1;
    end else if (head.kind.load_desc) begin
      desc_we = 1'b1;
      if (MW'(head.msg_index) == cur_msg) begin
        cur_desc_next = head.desc;
      end
    end else if (head.kind.start) begin
      if (!busy) begin
        msgs_left_next  = head.msg_count;
        cur_msg_next    = '0;
        msg_offset_next = '0;
        busy_next       = 1'b1;
        do_begin        = 1'b1;
        begin_off       = '0;
      end
    end else if (head.kind.ev) begin
      if ((pending & EV_ERR) != '0) begin
        do_finish = 1'b1;
        fin_code  = STAT_IO_ERR;
      end else if ((pending & EV_RX) != '0) begin
        mem_we          = 1'b1;
        waddr           = msg_offset + AW'(byte_count);
        byte_count_next = bc_inc;
        if (bc_inc >= cur_desc.len) begin
          event_mask_next = (event_mask & ~EV_RX) | EV_COMP;
        end else if (({1'b0, bc_inc} + 12'd1) == {1'b0, cur_desc.len}) begin
          res.send_stop = 1'b1;
        end
      end else if ((pending & EV_TX) != '0) begin
        if (byte_count >= cur_desc.len) begin
          event_mask_next = (event_mask & ~EV_TX) | EV_COMP;
          res.send_stop   = 1'b1;
        end else begin
          res.tx_valid    = 1'b1;
          tx_sel          = 1'b1;
          raddr           = msg_offset + AW'(byte_count);
          byte_count_next = bc_inc;
        end
      end else if ((pending & EV_COMP) != '0) begin
        event_mask_next = event_mask & ~EV_COMP;
        if (msgs_left > 4'd1) begin
          msgs_left_next  = msgs_left - 4'd1;
          msg_offset_next = off_adv;
          cur_msg_next    = cur_msg + 1'b1;
          do_begin        = 1'b1;
          begin_off       = off_adv;
        end else begin
          do_finish = 1'b1;
          fin_code  = STAT_OK;
        end
      end
    end else if (head.kind.timeout) begin
      if (busy) begin
        do_finish = 1'b1;
        fin_code  = STAT_TIMEOUT;
      end
    end else if (head.kind.read) begin
      rd_sel = 1'b1;
    end

    if (do_begin) begin
      res.mode_load   = 1'b1;
      res.target_addr = begin_desc.addr;
      cur_desc_next   = begin_desc;
      byte_count_next = '0;
      if (begin_desc.rd) begin
        res.read_mode   = 1'b1;
        res.send_start  = 1'b1;
        res.send_stop   = (begin_desc.len == 11'd1);
        event_mask_next = event_mask_next | EV_RX | EV_ERR;
      end else begin
        res.tx_valid    = 1'b1;
        tx_sel          = 1'b1;
        raddr           = begin_off;
        byte_count_next = 11'd1;
        event_mask_next = event_mask_next | EV_TX | EV_ERR;
      end
    end

    if (do_finish) begin
      event_mask_next = '0;
      busy_next       = 1'b0;
      res.done_res    = 1'b1;
      res.status      = fin_code;
    end

    res.watch_mask = event_mask_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      event_mask <= '0;
      cur_msg    <= '0;
      msgs_left  <= '0;
      byte_count <= '0;
      msg_offset <= '0;
      b_valid    <= 1'b0;
    end else begin
      b_valid <= a_fire;
      if (a_fire) begin
        busy       <= busy_next;
        event_mask <= event_mask_next;
        cur_msg    <= cur_msg_next;
        msgs_left  <= msgs_left_next;
        byte_count <= byte_count_next;
        msg_offset <= msg_offset_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      b_res    <= res;
      b_tx_sel <= tx_sel;
      b_rd_sel <= rd_sel;
      cur_desc <= cur_desc_next;
      rdata    <= mem[raddr];
      if (mem_we) begin
        mem[waddr] <= wdata;
      end
      if (desc_we) begin
        desc_tbl[MW'(head.msg_index)] <= head.desc;
      end
    end
  end

  always_comb begin
    res_data           = b_res;
    res_data.tx_byte   = b_tx_sel ? rdata : 8'd0;
    res_data.read_data = b_rd_sel ? rdata : 8'd0;
  end

  assign res_push = b_valid;

  // idle means nothing watched
  `IMSQ_ASSERT_IMP(a_idle_mask, clk, rst, !busy, event_mask == '0)
  `IMSQ_ASSERT_IMP(a_one_sel, clk, rst, b_valid, !(b_tx_sel && b_rd_sel))
  `IMSQ_ASSERT_NXT(a_fire_stage, clk, rst, a_fire, b_valid)
  `IMSQ_ASSERT_IMP(a_room, clk, rst, b_valid, res_level < LVL_W'(OUT_DEPTH))

endmodule

`default_nettype wire

// File: hdl/i2c_master_message_sequencer_unit.sv
// i2c message sequencer: requests enter through a queue-like port (push/full,
// payload req) and one result per request leaves through a queue-like port
// (empty/pop, payload res). A request is taken on an edge with push high and
// full low; the oldest result sits on res while empty is low and is taken on
// an edge with pop high.
// a result passes through the request queue, the execute stage register and
// the result queue. throughput: one request per cycle through the execute
// stage while the result queue has room; the stage does one byte-store access
// (one write port, one registered read port) and one descriptor lookup per request.
// a four-entry request queue and a four-entry result queue decouple the two
// sides; when the receiver stops popping, the result queue fills, execution
// pauses, then the request queue fills and full rises. nothing is lost.
// reset (rst, synchronous) empties both queues, clears the watch mask, the
// busy flag and all message counters; the byte store and descriptor table
// hold no defined value until loaded.
`default_nettype none

module i2c_master_message_sequencer_unit
  import imsq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t req,
  output logic          empty,
  input  wire logic     pop,
  output res_item_t     res
);

  logic             head_valid;
  work_t            head;
  logic             head_pop;
  logic [LVL_W-1:0] res_level;
  logic             res_push;
  res_item_t        res_data;

  imsq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req        (req),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  imsq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .res_level  (res_level),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  imsq_res_queue u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .in_push (res_push),
    .in_data (res_data),
    .level   (res_level),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import imsq_pkg::*;

  localparam int PLAN = 0;
  localparam int CHK = 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 750;
  localparam int MAX_PRINTS = 60;
  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_item_t req = '0;
  res_item_t res;

  // sequencer state, one copy for stimulus planning and one for checking
  logic [7:0] bstore[2][STORE_DEPTH];
  desc_t dtab[2][MAX_MSGS];
  bit [2:0] cur_msg[2];
  bit [3:0] msgs_left[2];
  bit [10:0] bcount[2];
  bit [9:0] offs[2];
  bit [3:0] emask[2];
  bit busy_q[2];
  bit written[STORE_DEPTH];
  int loaded[$];

  in_item_t request_queue[$];
  res_item_t due_responses[$];
  int n_items;
  int n_total;
  int n_sent;
  int n_popped;
  int n_errors;
  int cycles;
  int tx_gap;
  int rx_stall;
  logic holding = 1'b0;

  i2c_master_message_sequencer_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .req(req),
    .empty(empty),
    .pop(pop),
    .res(res)
  );

  always #4 clk = ~clk;

  task automatic store_byte(input int s, input logic [9:0] a, input logic [7:0] v);
    bstore[s][a] = v;
    if (s == PLAN && !written[a]) begin
      written[a] = 1'b1;
      loaded.push_back(int'(a));
    end
  endtask

  task automatic launch_message(input int s, inout res_item_t r);
    desc_t d;
    d = dtab[s][cur_msg[s]];
    bcount[s] = '0;
    r.mode_load = 1'b1;
    r.target_addr = d.addr;
    if (d.rd) begin
      r.read_mode = 1'b1;
      r.send_start = 1'b1;
      r.send_stop = (d.len == 11'd1);
      emask[s] = emask[s] | EV_RX | EV_ERR;
    end else begin
      r.tx_valid = 1'b1;
      r.tx_byte = bstore[s][offs[s]];
      bcount[s] = 11'd1;
      emask[s] = emask[s] | EV_TX | EV_ERR;
    end
  endtask

  task automatic close_transfer(input int s, input logic [1:0] code, inout res_item_t r);
    emask[s] = '0;
    busy_q[s] = 1'b0;
    r.done_res = 1'b1;
    r.status = code;
  endtask

  task automatic sequencer_step(input int s, input in_item_t it, output res_item_t r);
    desc_t d;
    logic [3:0] pend;
    logic [9:0] a;
    r = '0;
    d = dtab[s][cur_msg[s]];
    a = offs[s] + bcount[s][9:0];
    pend = {it.ev_error, it.ev_tx_complete, it.ev_tx_ready, it.ev_rx_ready} & emask[s];
    case (it.cmd)
      CMD_LOAD_BYTE: store_byte(s, it.buf_index, it.byte_value);
      CMD_LOAD_DESC: dtab[s][it.msg_index] = {it.dev_addr, it.is_read, it.msg_length};
      CMD_START: begin
        if (!busy_q[s]) begin
          msgs_left[s] = it.msg_count;
          cur_msg[s] = '0;
          offs[s] = '0;
          busy_q[s] = 1'b1;
          launch_message(s, r);
        end
      end
      CMD_EVENT: begin
        if ((pend & EV_ERR) != 4'd0) begin
          close_transfer(s, STAT_IO_ERR, r);
        end else if ((pend & EV_RX) != 4'd0) begin
          store_byte(s, a, it.byte_value);
          bcount[s] = bcount[s] + 11'd1;
          if (bcount[s] >= d.len) begin
            emask[s] = (emask[s] & ~EV_RX) | EV_COMP;
          end else if (int'(bcount[s]) + 1 == int'(d.len)) begin
            r.send_stop = 1'b1;
          end
        end else if ((pend & EV_TX) != 4'd0) begin
          if (bcount[s] >= d.len) begin
            emask[s] = (emask[s] & ~EV_TX) | EV_COMP;
            r.send_stop = 1'b1;
          end else begin
            r.tx_valid = 1'b1;
            r.tx_byte = bstore[s][a];
            bcount[s] = bcount[s] + 11'd1;
          end
        end else if ((pend & EV_COMP) != 4'd0) begin
          emask[s] = emask[s] & ~EV_COMP;
          if (msgs_left[s] > 4'd1) begin
            msgs_left[s] = msgs_left[s] - 4'd1;
            offs[s] = offs[s] + d.len[9:0];
            cur_msg[s] = cur_msg[s] + 3'd1;
            launch_message(s, r);
          end else begin
            close_transfer(s, STAT_OK, r);
          end
        end
      end
      CMD_TIMEOUT: begin
        if (busy_q[s]) close_transfer(s, STAT_TIMEOUT, r);
      end
      CMD_READ: r.read_data = bstore[s][it.buf_index];
      default: ;
    endcase
    r.watch_mask = emask[s];
  endtask

  // byte store address that a request would read in the planned state, -1 if none
  function automatic int fetch_addr(input in_item_t it);
    desc_t cur;
    logic [3:0] pend;
    logic [9:0] a;
    int addr;
    addr = -1;
    cur = dtab[PLAN][cur_msg[PLAN]];
    pend = {it.ev_error, it.ev_tx_complete, it.ev_tx_ready, it.ev_rx_ready} & emask[PLAN];
    if (it.cmd == CMD_READ) begin
      addr = int'(it.buf_index);
    end else if (it.cmd == CMD_START && !busy_q[PLAN] && !dtab[PLAN][0].rd) begin
      addr = 0;
    end else if (it.cmd == CMD_EVENT && (pend & (EV_ERR | EV_RX)) == 4'd0) begin
      if ((pend & EV_TX) != 4'd0) begin
        if (bcount[PLAN] < cur.len) begin
          a = offs[PLAN] + bcount[PLAN][9:0];
          addr = int'(a);
        end
      end else if ((pend & EV_COMP) != 4'd0 && msgs_left[PLAN] > 4'd1 &&
                   !dtab[PLAN][cur_msg[PLAN] + 3'd1].rd) begin
        a = offs[PLAN] + cur.len[9:0];
        addr = int'(a);
      end
    end
    return addr;
  endfunction

  function automatic in_item_t random_item(input logic [2:0] cmd);
    logic [63:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.cmd = cmd;
    return it;
  endfunction

  function automatic int idle_span(input int n);
    int pick;
    pick = $urandom_range(0, 99);
    if ((n / 64) % 4 == 3 || pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // no request may read a byte that was never loaded
  task automatic queue_request(input in_item_t it);
    in_item_t ld;
    res_item_t r;
    int a;
    a = fetch_addr(it);
    if (a >= 0 && !written[a]) begin
      if (it.cmd == CMD_READ) begin
        it.buf_index = 10'(loaded[$urandom_range(0, loaded.size() - 1)]);
      end else begin
        ld = random_item(CMD_LOAD_BYTE);
        ld.buf_index = 10'(a);
        sequencer_step(PLAN, ld, r);
        request_queue.push_back(ld);
        n_items++;
      end
    end
    sequencer_step(PLAN, it, r);
    request_queue.push_back(it);
    if (it.cmd <= CMD_READ) n_items++;
  endtask

  task automatic queue_byte(input logic [9:0] idx, input logic [7:0] val);
    in_item_t it;
    it = random_item(CMD_LOAD_BYTE);
    it.buf_index = idx;
    it.byte_value = val;
    queue_request(it);
  endtask

  task automatic queue_desc(input logic [2:0] slot, input logic [6:0] addr, input logic rd,
                            input logic [10:0] len);
    in_item_t it;
    it = random_item(CMD_LOAD_DESC);
    it.msg_index = slot;
    it.dev_addr = addr;
    it.is_read = rd;
    it.msg_length = len;
    queue_request(it);
  endtask

  task automatic queue_event(input logic [3:0] flags);
    in_item_t it;
    it = random_item(CMD_EVENT);
    {it.ev_error, it.ev_tx_complete, it.ev_tx_ready, it.ev_rx_ready} = flags;
    queue_request(it);
  endtask

  task automatic load_random_desc();
    int pick;
    logic [10:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 10) len = 11'd0;
    else if (pick < 80) len = 11'($urandom_range(1, 6));
    else if (pick < 95) len = 11'($urandom_range(7, 40));
    else len = 11'($urandom);
    queue_desc(3'($urandom), 7'($urandom), 1'($urandom), len);
  endtask

  task automatic noise_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) queue_request(random_item(CMD_LOAD_BYTE));
    else if (pick < 45) queue_request(random_item(CMD_READ));
    else if (pick < 55) load_random_desc();
    else if (pick < 70) queue_request(random_item(CMD_EVENT));
    else if (pick < 85) queue_request(random_item(CMD_TIMEOUT));
    else queue_request(random_item($urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B));
  endtask

  // the event the controller would raise next for the planned state
  task automatic serve_event();
    logic [3:0] f;
    if ((emask[PLAN] & EV_RX) != 4'd0) f = EV_RX;
    else if ((emask[PLAN] & EV_TX) != 4'd0) f = EV_TX;
    else f = EV_COMP;
    if ($urandom_range(0, 99) < 30) f = f | (4'($urandom) & ~EV_ERR);
    queue_event(f);
  endtask

  task automatic run_transfer();
    in_item_t it;
    int steps;
    int pick;
    int abort_pct;
    repeat ($urandom_range(0, 2)) load_random_desc();
    it = random_item(CMD_START);
    pick = $urandom_range(0, 99);
    if (pick < 5) it.msg_count = 4'd0;
    else if (pick < 15) it.msg_count = 4'($urandom_range(9, 15));
    else it.msg_count = 4'($urandom_range(1, 8));
    queue_request(it);
    abort_pct = ($urandom_range(0, 3) == 0) ? 6 : 0;
    steps = 0;
    while (busy_q[PLAN]) begin
      steps++;
      pick = $urandom_range(0, 99);
      if (pick < abort_pct || (steps > 60 && pick < 15)) begin
        if (pick % 2 == 0) queue_request(random_item(CMD_TIMEOUT));
        else queue_event(EV_ERR | 4'($urandom));
      end else if (pick < 88) begin
        serve_event();
      end else if (pick < 96) begin
        noise_request();
      end else begin
        queue_request(random_item(CMD_START));
      end
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    if (n_errors < MAX_PRINTS)
      $display("cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    n_errors++;
  endtask

  task automatic check_response(input res_item_t got, input res_item_t want);
    if (got.mode_load !== want.mode_load)
      report("mode_load", 64'(got.mode_load), 64'(want.mode_load));
    if (got.target_addr !== want.target_addr)
      report("target_addr", 64'(got.target_addr), 64'(want.target_addr));
    if (got.read_mode !== want.read_mode)
      report("read_mode", 64'(got.read_mode), 64'(want.read_mode));
    if (got.send_start !== want.send_start)
      report("send_start", 64'(got.send_start), 64'(want.send_start));
    if (got.send_stop !== want.send_stop)
      report("send_stop", 64'(got.send_stop), 64'(want.send_stop));
    if (got.tx_valid !== want.tx_valid)
      report("tx_valid", 64'(got.tx_valid), 64'(want.tx_valid));
    if (got.tx_byte !== want.tx_byte)
      report("tx_byte", 64'(got.tx_byte), 64'(want.tx_byte));
    if (got.watch_mask !== want.watch_mask)
      report("watch_mask", 64'(got.watch_mask), 64'(want.watch_mask));
    if (got.done_res !== want.done_res)
      report("done_res", 64'(got.done_res), 64'(want.done_res));
    if (got.status !== want.status)
      report("status", 64'(got.status), 64'(want.status));
    if (got.read_data !== want.read_data)
      report("read_data", 64'(got.read_data), 64'(want.read_data));
  endtask

  always @(posedge clk) begin : drive
    res_item_t want;
    if (rst) begin
      push <= 1'b0;
    end else if (!push || !full) begin
      if (push) begin
        sequencer_step(CHK, req, want);
        due_responses.push_back(want);
        n_sent++;
      end
      if (tx_gap > 0 && !holding) begin
        tx_gap--;
        push <= 1'b0;
      end else if (request_queue.size() != 0) begin
        req <= request_queue.pop_front();
        push <= 1'b1;
        tx_gap = idle_span(n_sent);
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : collect
    res_item_t want;
    if (rst) begin
      pop <= 1'b0;
      holding <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_popped++;
        if (due_responses.size() == 0) begin
          report("response with nothing due", 64'(res), 64'd0);
        end else begin
          want = due_responses.pop_front();
          check_response(res, want);
        end
        // long hold now and then so both queues fill and full rises
        rx_stall = (n_popped % 300 == 120) ? 150 : idle_span(n_popped + 32);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
      holding <= (rx_stall > 8);
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : main
    in_item_t it;
    // descriptor table fully loaded first: short, empty and maximal messages
    queue_desc(3'd0, 7'h7f, 1'b0, 11'd3);
    queue_desc(3'd1, 7'h00, 1'b1, 11'd1);
    queue_desc(3'd2, 7'h55, 1'b1, 11'd2);
    queue_desc(3'd3, 7'h2a, 1'b0, 11'd0);
    queue_desc(3'd4, 7'h15, 1'b1, 11'd0);
    queue_desc(3'd5, 7'h01, 1'b0, 11'd1);
    queue_desc(3'd6, 7'h7f, 1'b0, 11'h7ff);
    queue_desc(3'd7, 7'h40, 1'b1, 11'd1024);
    queue_byte(10'd0, 8'hff);
    queue_byte(10'd1, 8'h00);
    queue_byte(10'd2, 8'ha5);
    queue_byte(10'h3ff, 8'h5a);
    it = random_item(CMD_READ);
    it.buf_index = 10'h3ff;
    queue_request(it);
    // idle: timeout, masked events, unused code
    queue_request(random_item(CMD_TIMEOUT));
    queue_event(4'hf);
    queue_request(random_item(CMD_UNUSED_B));
    // zero message count runs one write message to the end
    it = random_item(CMD_START);
    it.msg_count = 4'd0;
    queue_request(it);
    repeat (3) queue_event(EV_TX);
    queue_event(EV_COMP);
    // start while busy, then a bus error
    it = random_item(CMD_START);
    it.msg_count = 4'hf;
    queue_request(it);
    queue_request(random_item(CMD_START));
    queue_event(4'hf);

    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 70) run_transfer();
      else repeat ($urandom_range(1, 4)) noise_request();
    end
    n_total = request_queue.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (n_sent < n_total || due_responses.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/imsq_pkg.sv
hdl/imsq_front.sv
hdl/imsq_res_queue.sv
hdl/imsq_back.sv
hdl/i2c_master_message_sequencer_unit.sv
tb/tb_top.sv
